@@ design/pbts_pkg.sv @@
// Shared types, codes and widths of the priority bitmap task scheduler.
package pbts_pkg;

  // Default parameter values
  localparam int unsigned NUM_PRIORITIES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 16;
  localparam int unsigned MAX_TASKS_DEF      = 16;

  // Field widths of the work word and the result word
  localparam int unsigned OP_W     = 3;
  localparam int unsigned TID_W    = 4;
  localparam int unsigned MSG_W    = 8;
  localparam int unsigned PRI_W    = 4;
  localparam int unsigned STATUS_W = 3;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_OP_LSB  = 0;
  localparam int unsigned IN_TID_LSB = IN_OP_LSB + OP_W;
  localparam int unsigned IN_MSG_LSB = IN_TID_LSB + TID_W;
  localparam int unsigned IN_REQ_LSB = IN_MSG_LSB + MSG_W;
  localparam int unsigned IN_TDATA_W = 24;

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_TID_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int unsigned OUT_MSG_LSB    = OUT_TID_LSB + TID_W;
  localparam int unsigned OUT_PRI_LSB    = OUT_MSG_LSB + MSG_W;
  localparam int unsigned OUT_PREV_LSB   = OUT_PRI_LSB + PRI_W;
  localparam int unsigned OUT_TDATA_W    = 24;

  // Ceiling stack
  localparam int unsigned STACK_SLOTS = 8;
  localparam int unsigned STK_IW      = $clog2(STACK_SLOTS);
  localparam int unsigned LVL_W       = STK_IW + 1;

  // Configuration registers
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_MAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_POST     = 3'd0,
    OP_DISPATCH = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_LOCK     = 3'd3,
    OP_UNLOCK   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_TASK = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NONE     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_PEND = 2'd2
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/pbts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbts_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pbts_ctrl.sv @@
// Controller state machine: sequences capture, execute and result load.
module pbts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pbts_pkg::dp_stat_t stat_i,
  output pbts_pkg::dp_cmd_t  cmd_o
);
  import pbts_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = CS_PEND;
      end
      CS_PEND: begin
        // Hand the result over and take the next word in the same cycle
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = CS_EXEC;
          end else begin
            state_d = CS_IDLE;
          end
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

@@ design/pbts_dp.sv @@
// Datapath: config registers, ready bitmap, queue pointers, ceiling stack, queue RAM.
module pbts_dp #(
  parameter int unsigned NUM_PRIORITIES = pbts_pkg::NUM_PRIORITIES_DEF,
  parameter int unsigned QUEUE_DEPTH    = pbts_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_TASKS      = pbts_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pbts_pkg::dp_cmd_t                cmd_i,
  output pbts_pkg::dp_stat_t               stat_o,
  input  logic [pbts_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                             cfg_we_i,
  input  logic [pbts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbts_pkg::MAP_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pbts_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import pbts_pkg::*;

  localparam int unsigned QW      = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int unsigned HW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MDEPTH  = NUM_PRIORITIES * QUEUE_DEPTH;
  localparam int unsigned AW      = $clog2(MDEPTH);
  localparam int unsigned ENTRY_W = TID_W + MSG_W;

  // Configuration
  logic [MAP_W-1:0] map_q;
  logic [CNT_W-1:0] cnt_q;

  // Captured work word
  logic [OP_W-1:0]  op_q;
  logic [TID_W-1:0] tid_q;
  logic [MSG_W-1:0] msg_q;
  logic [PRI_W-1:0] req_q;
  logic [PRI_W-1:0] in_req;
  logic [PRI_W-1:0] req_clamped;
  op_e              op_sel;

  // Scheduler state
  logic [NUM_PRIORITIES-1:0] ready_q;
  logic [PRI_W-1:0]          ceil_q;
  logic [HW-1:0]             head_q [NUM_PRIORITIES];
  logic [FW-1:0]             fill_q [NUM_PRIORITIES];
  logic [PRI_W-1:0]          stack_q [STACK_SLOTS];
  logic [LVL_W-1:0]          lvl_q;
  logic [LVL_W-1:0]          lvl_dec;

  // Pending result
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [PRI_W-1:0]    res_pri_q, res_pri_d;
  logic [PRI_W-1:0]    res_prev_q, res_prev_d;
  logic                res_mem_q, res_mem_d;

  // Output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [TID_W-1:0]    out_tid_q;
  logic [MSG_W-1:0]    out_msg_q;
  logic [PRI_W-1:0]    out_pri_q;
  logic [PRI_W-1:0]    out_prev_q;

  // Post decode
  logic [PRI_W-1:0] post_pri;
  logic             post_bad;
  logic [QW-1:0]    post_q;
  logic [FW-1:0]    post_fill;
  logic             post_full;
  logic             post_ok;
  logic [FW:0]      slot_sum;
  logic [HW-1:0]    post_slot;

  // Dispatch decode
  logic             top_any;
  logic [QW-1:0]    top_q;
  logic [PRI_W-1:0] top_p;
  logic [HW-1:0]    disp_head;
  logic [HW-1:0]    disp_head_next;
  logic [FW-1:0]    disp_fill;
  logic             disp_ok;

  // Complete, lock and unlock
  logic [PRI_W-1:0] pop_val;
  logic [PRI_W-1:0] lock_val;
  logic [PRI_W-1:0] unlock_val;

  // Queue memory
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // Clamp the requested ceiling on capture
  assign in_req      = in_data_i[IN_REQ_LSB +: PRI_W];
  assign req_clamped = (in_req > PRI_W'(NUM_PRIORITIES)) ? PRI_W'(NUM_PRIORITIES) : in_req;
  assign op_sel      = op_e'(op_q);

  // Post: look up task priority and the tail slot
  always_comb begin
    post_pri  = map_q[{tid_q, 2'b00} +: PRI_W];
    post_bad  = ({1'b0, tid_q} >= cnt_q) || ({1'b0, tid_q} >= CNT_W'(MAX_TASKS)) ||
                (post_pri == '0) || (post_pri > PRI_W'(NUM_PRIORITIES));
    post_q    = QW'(post_pri - PRI_W'(1));
    post_fill = fill_q[post_q];
    post_full = (post_fill == FW'(QUEUE_DEPTH));
    post_ok   = !post_bad && !post_full;
    slot_sum  = (FW+1)'(head_q[post_q]) + (FW+1)'(post_fill);
    if (slot_sum >= (FW+1)'(QUEUE_DEPTH)) begin
      post_slot = HW'(slot_sum - (FW+1)'(QUEUE_DEPTH));
    end else begin
      post_slot = HW'(slot_sum);
    end
  end

  // Dispatch: highest ready queue
  always_comb begin
    top_any = 1'b0;
    top_q   = '0;
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      if (ready_q[i]) begin
        top_any = 1'b1;
        top_q   = QW'(i);
      end
    end
    top_p          = PRI_W'(top_q) + PRI_W'(1);
    disp_head      = head_q[top_q];
    disp_fill      = fill_q[top_q];
    disp_head_next = (disp_head == HW'(QUEUE_DEPTH - 1)) ? '0 : disp_head + HW'(1);
    disp_ok        = top_any && (top_p > ceil_q) && (lvl_q < LVL_W'(STACK_SLOTS));
  end

  // Ceiling moves
  assign lvl_dec    = lvl_q - LVL_W'(1);
  assign pop_val    = stack_q[lvl_dec[STK_IW-1:0]];
  assign lock_val   = (req_q > ceil_q) ? req_q : ceil_q;
  assign unlock_val = (req_q < ceil_q) ? req_q : ceil_q;

  // Memory access for the executing word
  assign mem_we    = cmd_i.execute && (op_sel == OP_POST) && post_ok;
  assign mem_waddr = AW'(post_q) * AW'(QUEUE_DEPTH) + AW'(post_slot);
  assign mem_wdata = {tid_q, msg_q};
  assign mem_re    = cmd_i.execute && (op_sel == OP_DISPATCH) && disp_ok;
  assign mem_raddr = AW'(top_q) * AW'(QUEUE_DEPTH) + AW'(disp_head);

  pbts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MDEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result of the executing word
  always_comb begin
    res_status_d = STAT_OK;
    res_pri_d    = ceil_q;
    res_prev_d   = '0;
    res_mem_d    = 1'b0;
    unique case (op_sel)
      OP_POST: begin
        if (post_bad) begin
          res_status_d = STAT_BAD_TASK;
          res_pri_d    = '0;
        end else begin
          res_status_d = post_full ? STAT_FULL : STAT_OK;
          res_pri_d    = post_pri;
        end
      end
      OP_DISPATCH: begin
        if (disp_ok) begin
          res_pri_d  = top_p;
          res_prev_d = ceil_q;
          res_mem_d  = 1'b1;
        end else begin
          res_status_d = STAT_NONE;
        end
      end
      OP_COMPLETE: begin
        if (lvl_q == '0) begin
          res_status_d = STAT_EMPTY;
        end else begin
          res_pri_d = pop_val;
        end
      end
      OP_LOCK: begin
        res_pri_d  = lock_val;
        res_prev_d = ceil_q;
      end
      OP_UNLOCK: begin
        res_pri_d  = unlock_val;
        res_prev_d = ceil_q;
      end
      default: ;
    endcase
  end

  // Control state: config, bitmap, pointers, ceiling, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      cnt_q       <= '0;
      ready_q     <= '0;
      ceil_q      <= '0;
      head_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PRIORITY_MAP: map_q <= cfg_data_i;
          REG_TASK_COUNT:   cnt_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.execute) begin
        unique case (op_sel)
          OP_POST: begin
            if (post_ok) begin
              fill_q[post_q]  <= post_fill + FW'(1);
              ready_q[post_q] <= 1'b1;
            end
          end
          OP_DISPATCH: begin
            if (disp_ok) begin
              head_q[top_q] <= disp_head_next;
              fill_q[top_q] <= disp_fill - FW'(1);
              if (disp_fill == FW'(1)) begin
                ready_q[top_q] <= 1'b0;
              end
              lvl_q  <= lvl_q + LVL_W'(1);
              ceil_q <= top_p;
            end
          end
          OP_COMPLETE: begin
            if (lvl_q != '0) begin
              lvl_q  <= lvl_dec;
              ceil_q <= pop_val;
            end
          end
          OP_LOCK:   ceil_q <= lock_val;
          OP_UNLOCK: ceil_q <= unlock_val;
          default: ;
        endcase
      end
      // Hold the result until taken
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: captured word, stack slots, pending result, output fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_data_i[IN_OP_LSB +: OP_W];
      tid_q <= in_data_i[IN_TID_LSB +: TID_W];
      msg_q <= in_data_i[IN_MSG_LSB +: MSG_W];
      req_q <= req_clamped;
    end
    if (cmd_i.execute) begin
      if ((op_sel == OP_DISPATCH) && disp_ok) begin
        stack_q[lvl_q[STK_IW-1:0]] <= ceil_q;
      end
      res_status_q <= res_status_d;
      res_pri_q    <= res_pri_d;
      res_prev_q   <= res_prev_d;
      res_mem_q    <= res_mem_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_tid_q    <= res_mem_q ? mem_rdata[MSG_W +: TID_W] : '0;
      out_msg_q    <= res_mem_q ? mem_rdata[MSG_W-1:0] : '0;
      out_pri_q    <= res_pri_q;
      out_prev_q   <= res_prev_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = {1'b0, out_prev_q, out_pri_q, out_msg_q, out_tid_q, out_status_q};

endmodule

@@ design/priority_bitmap_task_scheduler.sv @@
// Top level of the priority bitmap task scheduler.
//
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    op, task_id, msg_handle, priority_req
// m_axis    out  m_axis_tvalid / m_axis_tready    status, out_task_id, out_msg_handle,
//                                                 out_priority, previous_priority
// cfg       in   cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// Each word is captured, then executed: the queue RAM write (post) or read
// (dispatch) runs with the bitmap, pointer and ceiling update.
// The result enters the output register once it is free, and the next word can be taken in that same cycle.
// A stalled m_axis holds one result and blocks the following one after execute.
// Reset clears bitmap, pointers, fill counts, ceiling, stack level and config;
// the queue RAM and ceiling stack need no clearing.
module priority_bitmap_task_scheduler #(
  parameter int unsigned NUM_PRIORITIES = pbts_pkg::NUM_PRIORITIES_DEF,
  parameter int unsigned QUEUE_DEPTH    = pbts_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_TASKS      = pbts_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] op, [6:3] task_id, [14:7] msg_handle, [18:15] priority_req, [23:19] zero
  input  logic [pbts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [6:3] out_task_id, [14:7] out_msg_handle, [18:15] out_priority,
  // [22:19] previous_priority, [23] zero
  output logic [pbts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pbts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pbts_pkg::MAP_W-1:0]       cfg_data_i
);
  import pbts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     s_accept;

  assign cfg_ready_o = 1'b1;
  assign s_accept    = s_axis_tvalid && s_axis_tready;

  pbts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbts_dp #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_TASKS      (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A taken word blocks the input while it executes
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_accept |=> !s_axis_tready)
    else $error("input taken during execute");

  // A result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.load_out |-> stat.out_free)
    else $error("output register overwritten");

  // Status code stays within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_STATUS_LSB +: STATUS_W] <= STAT_EMPTY))
    else $error("undefined status code");

  // Reported priority never exceeds the top level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_PRI_LSB +: PRI_W] <= PRI_W'(NUM_PRIORITIES)))
    else $error("priority out of range");

endmodule

@@ bench/pbts_checker.sv @@
// Scoreboard for the scheduler: predicts every result word and compares it on the master side.
`timescale 1ns / 100ps
module pbts_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // [2:0] op, [6:3] task_id, [14:7] msg_handle, [18:15] priority_req, [23:19] zero
  input  logic [pbts_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // [2:0] status, [6:3] out_task_id, [14:7] out_msg_handle, [18:15] out_priority,
  // [22:19] previous_priority, [23] zero
  input  logic [pbts_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [pbts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pbts_pkg::MAP_W-1:0]       cfg_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      results_owed_o
);
  import pbts_pkg::*;

  localparam int unsigned LEVELS = NUM_PRIORITIES_DEF;
  localparam int unsigned DEPTH  = QUEUE_DEPTH_DEF;
  localparam int unsigned PTR_W  = $clog2(DEPTH);

  typedef struct packed {
    status_e          status;
    logic [TID_W-1:0] task_id;
    logic [MSG_W-1:0] msg;
    logic [PRI_W-1:0] pri;
    logic [PRI_W-1:0] prev;
  } sched_result_t;

  // Configuration copy
  logic [MAP_W-1:0] prio_map;
  logic [CNT_W-1:0] task_total;

  // Scheduler state copy
  logic [LEVELS-1:0]      ready_mask;
  logic [PRI_W-1:0]       ceiling;
  logic [TID_W+MSG_W-1:0] msg_ring      [LEVELS][DEPTH];
  logic [PTR_W-1:0]       ring_head     [LEVELS];
  logic [PTR_W:0]         ring_fill     [LEVELS];
  logic [PRI_W-1:0]       saved_ceiling [STACK_SLOTS];
  logic [LVL_W-1:0]       saved_count;

  sched_result_t owed_results [$];
  int unsigned   errs = 0;

  // Apply one input word to the state copy and return the result it causes
  function automatic sched_result_t schedule_word(logic [IN_TDATA_W-1:0] w);
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] tid;
    logic [MSG_W-1:0] msg;
    logic [PRI_W-1:0] req;
    logic [PRI_W-1:0] p;
    logic [PRI_W-1:0] best;
    logic [PTR_W-1:0] slot;
    int               q;
    sched_result_t    r;
    op   = w[IN_OP_LSB +: OP_W];
    tid  = w[IN_TID_LSB +: TID_W];
    msg  = w[IN_MSG_LSB +: MSG_W];
    req  = w[IN_REQ_LSB +: PRI_W];
    // oversized requests saturate at the top level
    if (req > NUM_PRIORITIES_DEF) req = PRI_W'(NUM_PRIORITIES_DEF);
    r        = '0;
    r.status = STAT_OK;
    best     = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (ready_mask[i]) best = PRI_W'(i + 1);
    end
    case (op)
      OP_POST: begin
        p = prio_map[tid*PRI_W +: PRI_W];
        if (tid >= task_total || p < 1 || p > NUM_PRIORITIES_DEF) begin
          r.status = STAT_BAD_TASK;
        end else begin
          q     = p - 1;
          r.pri = p;
          if (ring_fill[q] >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            slot              = ring_head[q] + PTR_W'(ring_fill[q]);
            msg_ring[q][slot] = {tid, msg};
            ring_fill[q]++;
            ready_mask[q]     = 1'b1;
          end
        end
      end
      OP_DISPATCH: begin
        if (best == 0 || best <= ceiling || saved_count >= STACK_SLOTS) begin
          r.status = STAT_NONE;
          r.pri    = ceiling;
        end else begin
          q                    = best - 1;
          {r.task_id, r.msg}   = msg_ring[q][ring_head[q]];
          ring_head[q]++;
          ring_fill[q]--;
          if (ring_fill[q] == 0) ready_mask[q] = 1'b0;
          saved_ceiling[saved_count[STK_IW-1:0]] = ceiling;
          saved_count++;
          r.prev  = ceiling;
          ceiling = best;
          r.pri   = best;
        end
      end
      OP_COMPLETE: begin
        if (saved_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          saved_count--;
          ceiling = saved_ceiling[saved_count[STK_IW-1:0]];
        end
        r.pri = ceiling;
      end
      OP_LOCK: begin
        r.prev = ceiling;
        if (req > ceiling) ceiling = req;
        r.pri = ceiling;
      end
      OP_UNLOCK: begin
        r.prev = ceiling;
        if (req < ceiling) ceiling = req;
        r.pri = ceiling;
      end
      default: r.pri = ceiling;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [MSG_W-1:0] want,
                                      logic [MSG_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  // Track config, retire result words, then queue the prediction for a new word
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      prio_map    = '0;
      task_total  = '0;
      ready_mask  = '0;
      ceiling     = '0;
      saved_count = '0;
      for (int i = 0; i < LEVELS; i++) begin
        ring_head[i] = '0;
        ring_fill[i] = '0;
      end
      owed_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (owed_results.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_tdata_i);
          errs++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, m_tdata_i[OUT_STATUS_LSB +: STATUS_W]);
          check_field("out_task_id", want.task_id, m_tdata_i[OUT_TID_LSB +: TID_W]);
          check_field("out_msg_handle", want.msg, m_tdata_i[OUT_MSG_LSB +: MSG_W]);
          check_field("out_priority", want.pri, m_tdata_i[OUT_PRI_LSB +: PRI_W]);
          check_field("previous_priority", want.prev, m_tdata_i[OUT_PREV_LSB +: PRI_W]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PRIORITY_MAP: prio_map   = cfg_data_i;
          REG_TASK_COUNT:   task_total = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) owed_results.push_back(schedule_word(s_tdata_i));
    end
    results_owed_o <= owed_results.size();
    fail_count_o   <= errs;
  end

endmodule

@@ bench/tb_priority_bitmap_task_scheduler.sv @@
// Stimulus and verdict for the priority bitmap task scheduler.
`timescale 1ns / 100ps
module tb_priority_bitmap_task_scheduler;
  import pbts_pkg::*;

  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_UNLOCK + 1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;
  localparam logic [PRI_W-1:0] PRI_TOP = PRI_W'(NUM_PRIORITIES_DEF);

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [2:0] op, [6:3] task_id, [14:7] msg_handle, [18:15] priority_req, [23:19] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [2:0] status, [6:3] out_task_id, [14:7] out_msg_handle, [18:15] out_priority,
  // [22:19] previous_priority, [23] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [MAP_W-1:0]       cfg_data_i;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned items_sent = 0;
  int unsigned cur_count  = 0;
  logic        hold_req   = 1'b0;
  logic        calm       = 1'b0;

  always #1 clk_i = ~clk_i;

  priority_bitmap_task_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pbts_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  function automatic logic [IN_TDATA_W-1:0] pack_word(logic [OP_W-1:0] op,
      logic [TID_W-1:0] tid, logic [MSG_W-1:0] msg, logic [PRI_W-1:0] req);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[IN_OP_LSB +: OP_W]   = op;
    w[IN_TID_LSB +: TID_W] = tid;
    w[IN_MSG_LSB +: MSG_W] = msg;
    w[IN_REQ_LSB +: PRI_W] = req;
    return w;
  endfunction

  // Mostly valid nibbles; bad_pct of them zero or above the top level
  function automatic logic [MAP_W-1:0] random_map(int unsigned bad_pct);
    logic [MAP_W-1:0] m;
    for (int i = 0; i < MAP_W / PRI_W; i++) begin
      if ($urandom_range(0, 99) < bad_pct) begin
        m[i*PRI_W +: PRI_W] = $urandom_range(0, 1) ? '0 :
            PRI_W'($urandom_range(NUM_PRIORITIES_DEF + 1, (1 << PRI_W) - 1));
      end else begin
        m[i*PRI_W +: PRI_W] = PRI_W'($urandom_range(1, NUM_PRIORITIES_DEF));
      end
    end
    return m;
  endfunction

  // Favor task ids that the current count makes valid
  function automatic logic [TID_W-1:0] pick_task();
    if (cur_count > 0 && $urandom_range(0, 9) != 0) begin
      return TID_W'($urandom_range(0, cur_count - 1));
    end
    return TID_W'($urandom);
  endfunction

  // Offer one word, with an optional idle burst ahead of it; leave tvalid high
  task automatic send_word(logic [IN_TDATA_W-1:0] w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop tvalid and hold until every result word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_config(logic [MAP_W-1:0] map, int unsigned count);
    cfg_write(REG_PRIORITY_MAP, map);
    cfg_write(REG_TASK_COUNT, MAP_W'(count));
    cfg_valid_i <= 1'b0;
    cur_count = count;
  endtask

  // Random operation mix; post_pct sets how much of it is posts
  task automatic run_mixed(int unsigned n, int unsigned post_pct);
    logic [OP_W-1:0]  op;
    logic [PRI_W-1:0] req;
    int unsigned      r;
    repeat (n) begin
      req = PRI_W'($urandom);
      if ($urandom_range(0, 99) < post_pct) begin
        op = OP_POST;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 8)       op = OP_DISPATCH;
        else if (r < 12) op = OP_COMPLETE;
        else if (r < 15) op = OP_LOCK;
        else if (r < 18) op = OP_UNLOCK;
        else             op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (op == OP_UNLOCK && $urandom_range(0, 1) == 0) req = '0;
      end
      send_word(pack_word(op, pick_task(), MSG_W'($urandom), req));
    end
  endtask

  // Burst of posts to one task, which can overflow its queue
  task automatic run_flood();
    logic [TID_W-1:0] tid;
    tid = pick_task();
    repeat ($urandom_range(14, 20)) begin
      send_word(pack_word(OP_POST, tid, MSG_W'($urandom), PRI_W'($urandom)));
    end
  endtask

  // Stack ceilings by dispatch and unlock pairs, which can fill the stack, then unwind
  task automatic run_climb();
    repeat ($urandom_range(6, 12)) begin
      send_word(pack_word(OP_POST, pick_task(), MSG_W'($urandom), PRI_W'($urandom)));
    end
    repeat ($urandom_range(8, 11)) begin
      send_word(pack_word(OP_DISPATCH, TID_W'($urandom), MSG_W'($urandom),
                          PRI_W'($urandom)));
      send_word(pack_word(OP_UNLOCK, TID_W'($urandom), MSG_W'($urandom),
                          $urandom_range(0, 3) == 0 ? PRI_W'($urandom_range(0, 2)) : '0));
    end
    repeat ($urandom_range(6, 10)) begin
      send_word(pack_word(OP_COMPLETE, TID_W'($urandom), MSG_W'($urandom),
                          PRI_W'($urandom)));
    end
  endtask

  task automatic run_phase(int unsigned n, int unsigned post_pct);
    int unsigned stop;
    int unsigned pick;
    stop = items_sent + n;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      run_mixed($urandom_range(8, 30), post_pct);
      else if (pick < 7) run_flood();
      else               run_climb();
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once no channel has moved a word for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no task is valid while the count is still at reset
    send_word(pack_word(OP_POST, 4'd3, 8'h5A, '0));
    drain();
    // task 0 at level 1, tasks 1 and 15 at the top, task 2 at zero, task 3 out of range
    write_config(64'h8765_4321_8724_F081, MAX_TASKS_DEF);
    send_word(pack_word(OP_POST, 4'd0, 8'h00, '0));
    send_word(pack_word(OP_POST, 4'd15, 8'hFF, '1));
    send_word(pack_word(OP_POST, 4'd1, 8'hA5, '0));
    send_word(pack_word(OP_POST, 4'd2, 8'h11, '0));
    send_word(pack_word(OP_POST, 4'd3, 8'h22, '0));
    send_word(pack_word(OP_DISPATCH, '0, '0, '0));
    // ceiling now at the top: nothing is above it
    send_word(pack_word(OP_DISPATCH, '1, '1, '1));
    send_word(pack_word(OP_UNLOCK, '0, '0, '1));
    send_word(pack_word(OP_UNLOCK, '1, '1, '0));
    send_word(pack_word(OP_DISPATCH, '0, '0, '0));
    send_word(pack_word(OP_UNLOCK, '0, '0, '0));
    send_word(pack_word(OP_DISPATCH, '0, '0, '0));
    // ceiling 1 with every queue empty
    send_word(pack_word(OP_DISPATCH, '0, '0, '0));
    repeat (4) send_word(pack_word(OP_COMPLETE, '0, '0, '0));
    send_word(pack_word(OP_LOCK, '0, '0, '1));
    send_word(pack_word(OP_LOCK, '0, '0, 4'd2));
    send_word(pack_word(OP_UNLOCK, '0, '0, 4'd3));
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) begin
      send_word(pack_word(OP_W'(c), TID_W'($urandom), MSG_W'($urandom), PRI_W'($urandom)));
    end
    drain();

    // Valid map, full count; long receiver hold in the middle
    write_config(random_map(0), MAX_TASKS_DEF);
    run_phase(120, 45);
    hold_req = 1'b1;
    run_phase(60, 45);
    run_phase(120, 35);
    drain();

    // Every nibble out of range
    write_config('1, MAX_TASKS_DEF);
    run_phase(40, 40);
    drain();

    // Mixed map with a partial count; sender pause until all results are back
    write_config(random_map(25), $urandom_range(1, MAX_TASKS_DEF - 1));
    run_phase(120, 45);
    drain();
    run_phase(130, 30);
    drain();

    // Empty map and zero count
    write_config('0, 0);
    run_phase(30, 40);
    drain();

    // Every task at the top level
    write_config({(MAP_W / PRI_W){PRI_TOP}}, MAX_TASKS_DEF);
    run_phase(150, 50);
    drain();

    // Closing stretch at full rate on both sides
    calm = 1'b1;
    write_config(random_map(10), MAX_TASKS_DEF);
    run_phase(300, 40);
    drain();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
